// ===== sv/nmt_pkg.sv =====
// Shared types and constants for the NAT mapping table.
package nmt_pkg;

	localparam int unsigned IP_W       = 32;
	localparam int unsigned PORT_W     = 16;
	localparam int unsigned TIME_W     = 32;
	localparam int unsigned SEQ_W      = 32;
	localparam int unsigned TO_W       = 16;
	localparam int unsigned OP_W       = 2;
	localparam int unsigned STATUS_W   = 2;
	localparam int unsigned EVICT_W    = 7;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 32;

	localparam logic [IP_W-1:0]   OUTSIDE_IP_RST = '0;
	localparam logic [TO_W-1:0]   QUERY_TO_RST   = 16'd60;
	localparam logic [TO_W-1:0]   SESSION_TO_RST = 16'd7440;
	localparam logic [PORT_W-1:0] PORT_LOW_RST   = 16'd1389;
	localparam logic [PORT_W-1:0] PORT_HIGH_RST  = 16'd35876;

	typedef enum logic [OP_W-1:0] {
		OP_LOOKUP_IN  = 2'd0,
		OP_LOOKUP_OUT = 2'd1,
		OP_INSERT     = 2'd2,
		OP_TICK       = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		STS_OK        = 2'd0,
		STS_MISS      = 2'd1,
		STS_FULL      = 2'd2,
		STS_TICK_DONE = 2'd3
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_OUTSIDE_IP = 3'd0,
		CFG_QUERY_TO   = 3'd1,
		CFG_SESSION_TO = 3'd2,
		CFG_PORT_LOW   = 3'd3,
		CFG_PORT_HIGH  = 3'd4
	} cfg_reg_t;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_FINISH
	} fsm_t;

	typedef struct packed {
		logic              valid;
		logic              kind;
		logic [IP_W-1:0]   inside_ip;
		logic [PORT_W-1:0] inside_port;
		logic [PORT_W-1:0] outside_port;
		logic [TIME_W-1:0] last_seen;
		logic [SEQ_W-1:0]  age_order;
	} entry_t;

endpackage

// ===== sv/nmt_if.sv =====
// Request and response channel interfaces of the NAT mapping table.
interface nmt_req_if
	import nmt_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   op;
	logic              proto;
	logic [IP_W-1:0]   inside_ip;
	logic [PORT_W-1:0] inside_port;
	logic [PORT_W-1:0] outside_port;

	modport source (output valid, op, proto, inside_ip, inside_port, outside_port,
		input ready);
	modport sink (input valid, op, proto, inside_ip, inside_port, outside_port,
		output ready);
endinterface

interface nmt_rsp_if
	import nmt_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [IP_W-1:0]     found_inside_ip;
	logic [PORT_W-1:0]   found_inside_port;
	logic [IP_W-1:0]     found_outside_ip;
	logic [PORT_W-1:0]   found_outside_port;
	logic [EVICT_W-1:0]  evicted;

	modport source (output valid, status, found_inside_ip, found_inside_port,
		found_outside_ip, found_outside_port, evicted, input ready);
	modport sink (input valid, status, found_inside_ip, found_inside_port,
		found_outside_ip, found_outside_port, evicted, output ready);
endinterface

// ===== sv/nat_mapping_table_unit.sv =====
// NAT mapping table: slot memory scanned one entry per cycle by a small sequencer.
//
// Every request (inside lookup, outside lookup, insert, tick) sweeps all TABLE_ENTRIES
// slots of the single-port-read slot memory, one read per cycle with registered read
// data. It then drains the read pipeline and, in S_FINISH, writes back and loads the
// response register. The next request is taken only after the response register is
// loaded. The write-back step waits while the previous response has not been taken.
// One request is in work at a time; the next can be accepted while the previous
// response waits to be taken. After reset a clearing pass invalidates every slot before
// the first request is accepted; configuration writes are taken at any time.
module nat_mapping_table_unit
	import nmt_pkg::*;
#(
	parameter int TABLE_ENTRIES = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	nmt_req_if.sink               req,
	nmt_rsp_if.source             rsp
);

	localparam int AW = $clog2(TABLE_ENTRIES);
	localparam int CW = AW + 1;
	localparam logic [CW-1:0] IDX_END  = CW'(TABLE_ENTRIES);
	localparam logic [CW-1:0] IDX_LAST = CW'(TABLE_ENTRIES - 1);

	// configuration
	logic [IP_W-1:0]   outside_ip_q;
	logic [TO_W-1:0]   query_to_q;
	logic [TO_W-1:0]   session_to_q;
	logic [PORT_W-1:0] port_low_q;
	logic [PORT_W-1:0] port_high_q;

	// global state
	logic [TIME_W-1:0] seconds_q;
	logic [PORT_W-1:0] next_port_q;
	logic [SEQ_W-1:0]  seq_q;

	// sequencer
	fsm_t           state_q, state_d;
	logic [CW-1:0]  idx_q;
	logic           rd_vld_s1;
	logic [AW-1:0]  rd_idx_s1;
	entry_t         rd_data_s1;

	// request in work
	op_t               op_q;
	logic              kind_q;
	logic [IP_W-1:0]   ip_q;
	logic [PORT_W-1:0] iport_q;
	logic [PORT_W-1:0] oport_q;

	// scan results
	logic               found_q;
	logic [AW-1:0]      best_idx_q;
	entry_t             best_q;
	logic [SEQ_W-1:0]   best_d_q;
	logic [EVICT_W-1:0] evict_cnt_q;

	// response register
	logic                out_vld_q;
	status_t             out_status_q;
	logic [IP_W-1:0]     out_iip_q;
	logic [PORT_W-1:0]   out_iport_q;
	logic [IP_W-1:0]     out_oip_q;
	logic [PORT_W-1:0]   out_oport_q;
	logic [EVICT_W-1:0]  out_evicted_q;

	// slot memory
	entry_t        slot_mem [TABLE_ENTRIES];
	logic          mem_we;
	logic [AW-1:0] mem_wa;
	entry_t        mem_wd;
	logic          mem_re;
	logic [AW-1:0] mem_ra;

	logic              req_fire;
	logic              finish_go;
	logic              key_match;
	logic              is_match;
	logic [SEQ_W-1:0]  seq_dist;
	logic              newer;
	logic [TIME_W-1:0] idle;
	logic [TO_W-1:0]   limit;
	logic              evict_hit;
	logic [PORT_W-1:0] alloc_port;
	entry_t            new_entry;
	entry_t            touched_entry;

	assign req_fire = req.valid && req.ready;

	// per-slot evaluation of the registered read data
	always_comb begin
		if (op_q == OP_LOOKUP_OUT) begin
			key_match = rd_data_s1.outside_port == oport_q;
		end else begin
			key_match = (rd_data_s1.inside_ip == ip_q) && (rd_data_s1.inside_port == iport_q);
		end
		is_match = rd_data_s1.valid && (rd_data_s1.kind == kind_q) && key_match;
		seq_dist = seq_q - rd_data_s1.age_order;
		newer    = !found_q || (seq_dist < best_d_q);
		idle     = seconds_q - rd_data_s1.last_seen;
		limit    = rd_data_s1.kind ? session_to_q : query_to_q;
		evict_hit = rd_vld_s1 && (op_q == OP_TICK) && rd_data_s1.valid &&
			(idle > TIME_W'(limit));
	end

	// allocator: wrap to port_low once past port_high
	always_comb begin
		alloc_port = (next_port_q > port_high_q) ? port_low_q : next_port_q;
		new_entry.valid        = 1'b1;
		new_entry.kind         = kind_q;
		new_entry.inside_ip    = ip_q;
		new_entry.inside_port  = iport_q;
		new_entry.outside_port = alloc_port;
		new_entry.last_seen    = seconds_q;
		new_entry.age_order    = seq_q + SEQ_W'(1);
		touched_entry           = best_q;
		touched_entry.last_seen = seconds_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_wa    = rd_idx_s1;
		mem_wd    = rd_data_s1;
		mem_re    = 1'b0;
		mem_ra    = idx_q[AW-1:0];
		req.ready = 1'b0;
		finish_go = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				mem_we = 1'b1;
				mem_wa = idx_q[AW-1:0];
				mem_wd = '0;
				if (idx_q == IDX_LAST) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				mem_re = idx_q != IDX_END;
				if (evict_hit) begin
					mem_we       = 1'b1;
					mem_wd.valid = 1'b0;
				end
				if (idx_q == IDX_END && !rd_vld_s1) begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				if (!out_vld_q || rsp.ready) begin
					finish_go = 1'b1;
					state_d   = S_IDLE;
					mem_wa    = best_idx_q;
					if (found_q && op_q == OP_INSERT) begin
						mem_we = 1'b1;
						mem_wd = new_entry;
					end else if (found_q && op_q != OP_TICK) begin
						mem_we = 1'b1;
						mem_wd = touched_entry;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			slot_mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rd_data_s1 <= slot_mem[mem_ra];
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outside_ip_q <= OUTSIDE_IP_RST;
			query_to_q   <= QUERY_TO_RST;
			session_to_q <= SESSION_TO_RST;
			port_low_q   <= PORT_LOW_RST;
			port_high_q  <= PORT_HIGH_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_OUTSIDE_IP: outside_ip_q <= cfg_wdata[IP_W-1:0];
				CFG_QUERY_TO:   query_to_q   <= cfg_wdata[TO_W-1:0];
				CFG_SESSION_TO: session_to_q <= cfg_wdata[TO_W-1:0];
				CFG_PORT_LOW:   port_low_q   <= cfg_wdata[PORT_W-1:0];
				CFG_PORT_HIGH:  port_high_q  <= cfg_wdata[PORT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			rd_vld_s1   <= 1'b0;
			found_q     <= 1'b0;
			evict_cnt_q <= '0;
			seconds_q   <= '0;
			next_port_q <= PORT_LOW_RST;
			seq_q       <= '0;
			out_vld_q   <= 1'b0;
		end else begin
			rd_vld_s1 <= mem_re;
			case (state_q)
				S_CLEAR: begin
					idx_q <= (idx_q == IDX_LAST) ? '0 : idx_q + CW'(1);
				end
				S_SCAN: begin
					if (idx_q != IDX_END) begin
						idx_q <= idx_q + CW'(1);
					end
				end
				default: begin
				end
			endcase
			if (req_fire) begin
				idx_q       <= '0;
				found_q     <= 1'b0;
				evict_cnt_q <= '0;
				if (op_t'(req.op) == OP_TICK) begin
					seconds_q <= seconds_q + TIME_W'(1);
				end
			end
			if (rd_vld_s1) begin
				if (op_q == OP_INSERT) begin
					if (!rd_data_s1.valid && !found_q) begin
						found_q <= 1'b1;
					end
				end else if (op_q != OP_TICK) begin
					if (is_match && newer) begin
						found_q <= 1'b1;
					end
				end
			end
			if (evict_hit && evict_cnt_q != '1) begin
				evict_cnt_q <= evict_cnt_q + EVICT_W'(1);
			end
			if (finish_go && found_q && op_q == OP_INSERT) begin
				seq_q       <= seq_q + SEQ_W'(1);
				next_port_q <= alloc_port + PORT_W'(1);
			end
			if (finish_go) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		rd_idx_s1 <= mem_ra;
		if (req_fire) begin
			op_q    <= op_t'(req.op);
			kind_q  <= req.proto;
			ip_q    <= req.inside_ip;
			iport_q <= req.inside_port;
			oport_q <= req.outside_port;
		end
		if (rd_vld_s1) begin
			if (op_q == OP_INSERT) begin
				if (!rd_data_s1.valid && !found_q) begin
					best_idx_q <= rd_idx_s1;
				end
			end else if (is_match && newer) begin
				best_idx_q <= rd_idx_s1;
				best_q     <= rd_data_s1;
				best_d_q   <= seq_dist;
			end
		end
		if (finish_go) begin
			out_iip_q     <= '0;
			out_iport_q   <= '0;
			out_oip_q     <= '0;
			out_oport_q   <= '0;
			out_evicted_q <= '0;
			case (op_q)
				OP_TICK: begin
					out_status_q  <= STS_TICK_DONE;
					out_evicted_q <= evict_cnt_q;
				end
				OP_INSERT: begin
					if (found_q) begin
						out_status_q <= STS_OK;
						out_iip_q    <= ip_q;
						out_iport_q  <= iport_q;
						out_oip_q    <= outside_ip_q;
						out_oport_q  <= alloc_port;
					end else begin
						out_status_q <= STS_FULL;
					end
				end
				default: begin
					if (found_q) begin
						out_status_q <= STS_OK;
						out_iip_q    <= best_q.inside_ip;
						out_iport_q  <= best_q.inside_port;
						out_oip_q    <= outside_ip_q;
						out_oport_q  <= best_q.outside_port;
					end else begin
						out_status_q <= STS_MISS;
					end
				end
			endcase
		end
	end

	assign rsp.valid              = out_vld_q;
	assign rsp.status             = out_status_q;
	assign rsp.found_inside_ip    = out_iip_q;
	assign rsp.found_inside_port  = out_iport_q;
	assign rsp.found_outside_ip   = out_oip_q;
	assign rsp.found_outside_port = out_oport_q;
	assign rsp.evicted            = out_evicted_q;

endmodule
